/* hdl/sbm_pkg.sv */
package sbm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANKS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_CHR_ROM = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRAM_MODE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_MIRROR = 3'd3;

    // configuration reset values
    localparam logic [6:0] RESET_ROM_BANKS   = 7'd8;
    localparam logic       RESET_HAS_CHR_ROM = 1'b1;
    localparam logic [1:0] RESET_WRAM_MODE   = 2'd0;
    localparam logic [1:0] RESET_INIT_MIRROR = 2'd2;

    // register select codes from address bits 14:13
    localparam logic [1:0] SEL_CONTROL = 2'd0;
    localparam logic [1:0] SEL_CHR_A   = 2'd1;
    localparam logic [1:0] SEL_CHR_B   = 2'd2;
    localparam logic [1:0] SEL_PRG     = 2'd3;

    // work ram page select modes
    localparam logic [1:0] WRAM_MODE_BFFF = 2'd1;
    localparam logic [1:0] WRAM_MODE_CHR  = 2'd2;

    localparam logic [4:0]  CTRL_RESET    = 5'h0c;
    localparam logic [4:0]  CTRL_PRG_MODE = 5'h0c;
    localparam logic [15:0] BFFF_ADDR     = 16'hbfff;
    localparam logic [6:0]  LARGE_BANKS   = 7'd32;
    localparam logic [2:0]  LOAD_BITS     = 3'd5;
    localparam logic [2:0]  WRAM_WRITES   = 3'd5;
    localparam logic [5:0]  LARGE_FIXED   = 6'd15;
    localparam logic [4:0]  CHR_RESET_HI  = 5'd1;

    typedef struct packed {
        logic [6:0] rom_banks_16k;
        logic       has_chr_rom;
        logic [1:0] wram_mode;
        logic [1:0] initial_mirroring;
    } cfg_t;

endpackage

/* hdl/serial_bank_mapper_unit.sv */
// throughput: one transaction per cycle while the output is not stalled;
//   input register, one pass of select and add logic that also updates the
//   mapper state, then the result register
// reset: rst_n clears the pipeline and loads the default configuration and
//   mapper state; a configuration write reloads the mapper state from the new values
module serial_bank_mapper_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [sbm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sbm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [15:0]                    addr,
    input  logic [7:0]                     data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     mirroring,
    output logic [5:0]                     prg_bank_low,
    output logic [5:0]                     prg_bank_high,
    output logic [4:0]                     chr_bank_low,
    output logic [4:0]                     chr_bank_high,
    output logic                           wram_page,
    output logic                           register_loaded
);
    import sbm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic cfg_hit;
    logic large_next;
    logic [5:0] reset_prg_high;

    logic s1_valid_reg;
    logic [15:0] s1_addr_reg;
    logic [7:0] s1_data_reg;
    logic s1_fire;
    logic out_valid_reg;

    logic [2:0] bit_count_reg, bit_count_next;
    logic [4:0] shift_reg, shift_next;
    logic [4:0] ctrl_reg, ctrl_next;
    logic [4:0] chr_a_reg, chr_a_next;
    logic [4:0] chr_b_reg, chr_b_next;
    logic [4:0] prg_reg, prg_next;
    logic [1:0] last_sel_reg, last_sel_next;
    logic [2:0] wram_count_reg, wram_count_next;
    logic [2:0] wram_sum_reg, wram_sum_next;
    logic [1:0] mirroring_reg, mirroring_next;
    logic [5:0] prg_low_reg, prg_low_next;
    logic [5:0] prg_high_reg, prg_high_next;
    logic [4:0] chr_low_reg, chr_low_next;
    logic [4:0] chr_high_reg, chr_high_next;
    logic wram_page_reg, wram_page_next;
    logic loaded_reg, loaded_next;

    logic large_mode;
    logic [1:0] sel;
    logic [6:0] last_bank;
    logic [2:0] count_base;
    logic [4:0] buf_base;
    logic [2:0] count_inc;
    logic [2:0] sum_inc;
    logic [5:0] base;
    logic [5:0] large_switch;

    // configuration decode
    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_hit  = 1'b0;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_ROM_BANKS:
                begin
                    cfg_next.rom_banks_16k = cfg_data;
                    cfg_hit = 1'b1;
                end
                CFG_HAS_CHR_ROM:
                begin
                    cfg_next.has_chr_rom = cfg_data[0];
                    cfg_hit = 1'b1;
                end
                CFG_WRAM_MODE:
                begin
                    cfg_next.wram_mode = cfg_data[1:0];
                    cfg_hit = 1'b1;
                end
                CFG_INIT_MIRROR:
                begin
                    cfg_next.initial_mirroring = cfg_data[1:0];
                    cfg_hit = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign large_next = (cfg_next.rom_banks_16k >= LARGE_BANKS);
    assign reset_prg_high = large_next ? LARGE_FIXED
                                       : 6'(cfg_next.rom_banks_16k - 7'd1);

    // handshake
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_addr_reg <= addr;
            s1_data_reg <= data;
        end
    end

    // one write through the serial port
    assign large_mode = (cfg_reg.rom_banks_16k >= LARGE_BANKS);
    assign sel        = s1_addr_reg[14:13];
    assign last_bank  = cfg_reg.rom_banks_16k - 7'd1;
    assign count_inc  = wram_count_reg + 3'd1;
    assign sum_inc    = wram_sum_reg + {2'b00, s1_data_reg[0]};

    always_comb
    begin
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        ctrl_next       = ctrl_reg;
        chr_a_next      = chr_a_reg;
        chr_b_next      = chr_b_reg;
        prg_next        = prg_reg;
        last_sel_next   = last_sel_reg;
        wram_count_next = wram_count_reg;
        wram_sum_next   = wram_sum_reg;
        mirroring_next  = mirroring_reg;
        prg_low_next    = prg_low_reg;
        prg_high_next   = prg_high_reg;
        chr_low_next    = chr_low_reg;
        chr_high_next   = chr_high_reg;
        wram_page_next  = wram_page_reg;
        loaded_next     = 1'b0;
        count_base      = bit_count_reg;
        buf_base        = shift_reg;
        base            = 6'd0;
        large_switch    = 6'd0;

        // five writes to bfff pick the work ram page
        if (cfg_reg.wram_mode == WRAM_MODE_BFFF && s1_addr_reg == BFFF_ADDR)
        begin
            if (count_inc == WRAM_WRITES)
            begin
                wram_page_next  = (sum_inc != 3'd0);
                wram_count_next = 3'd0;
                wram_sum_next   = 3'd0;
            end
            else
            begin
                wram_count_next = count_inc;
                wram_sum_next   = sum_inc;
            end
        end

        // normal mode drops a partial load when the register select moves
        if (!large_mode)
        begin
            if (sel != last_sel_reg)
            begin
                count_base = 3'd0;
                buf_base   = 5'd0;
            end
            last_sel_next = sel;
        end

        bit_count_next = count_base;
        shift_next     = buf_base;
        if (s1_data_reg[7])
        begin
            bit_count_next = 3'd0;
            shift_next     = 5'd0;
            ctrl_next      = ctrl_reg | CTRL_PRG_MODE;
        end
        else
        begin
            shift_next     = buf_base | (5'(s1_data_reg[0]) << count_base);
            bit_count_next = count_base + 3'd1;
            if (bit_count_next >= LOAD_BITS)
            begin
                case (sel)
                    SEL_CONTROL: ctrl_next  = shift_next;
                    SEL_CHR_A:   chr_a_next = shift_next;
                    SEL_CHR_B:   chr_b_next = shift_next;
                    default:     prg_next   = shift_next;
                endcase
                shift_next     = 5'd0;
                bit_count_next = 3'd0;
                loaded_next    = 1'b1;

                if (large_mode)
                begin
                    base         = {1'b0, chr_a_next[4], 4'b0000};
                    large_switch = base + {2'b00, prg_next[3:0]};
                    if (cfg_reg.wram_mode == WRAM_MODE_CHR)
                        wram_page_next = (chr_a_next[4:3] != 2'b00);
                    if (sel == SEL_CONTROL)
                        mirroring_next = ctrl_next[1:0];
                    if (cfg_reg.has_chr_rom || ctrl_next[4])
                    begin
                        if (ctrl_next[4])
                        begin
                            chr_low_next  = chr_a_next;
                            chr_high_next = chr_b_next;
                        end
                        else
                        begin
                            chr_low_next  = {chr_a_next[4:1], 1'b0};
                            chr_high_next = {chr_a_next[4:1], 1'b1};
                        end
                    end
                    if (!ctrl_next[3])
                    begin
                        prg_low_next  = base + {2'b00, prg_next[3:1], 1'b0};
                        prg_high_next = prg_low_next + 6'd1;
                    end
                    else if (ctrl_next[2])
                    begin
                        prg_low_next  = large_switch;
                        prg_high_next = base + LARGE_FIXED;
                    end
                    else
                    begin
                        prg_low_next  = base;
                        prg_high_next = large_switch;
                    end
                end
                else
                begin
                    case (sel) inside
                        SEL_CONTROL:
                        begin
                            mirroring_next = ctrl_next[1:0];
                        end
                        SEL_CHR_A, SEL_CHR_B:
                        begin
                            if (cfg_reg.has_chr_rom)
                            begin
                                if (ctrl_next[4])
                                begin
                                    chr_low_next  = chr_a_next;
                                    chr_high_next = chr_b_next;
                                end
                                else
                                begin
                                    chr_low_next  = {chr_a_next[4:1], 1'b0};
                                    chr_high_next = {chr_a_next[4:1], 1'b1};
                                end
                            end
                            else if (ctrl_next[4])
                            begin
                                // chr ram: each register moves only its own half
                                if (sel == SEL_CHR_A)
                                    chr_low_next = chr_a_next;
                                else
                                    chr_high_next = chr_b_next;
                            end
                        end
                        default:
                        begin
                            if (!ctrl_next[3])
                            begin
                                prg_low_next  = {1'b0, prg_next[4:1], 1'b0};
                                prg_high_next = {1'b0, prg_next[4:1], 1'b1};
                            end
                            else if (ctrl_next[2])
                            begin
                                prg_low_next  = {1'b0, prg_next};
                                prg_high_next = last_bank[5:0];
                            end
                            else
                            begin
                                prg_low_next  = 6'd0;
                                prg_high_next = {1'b0, prg_next};
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rom_banks_16k     <= RESET_ROM_BANKS;
            cfg_reg.has_chr_rom       <= RESET_HAS_CHR_ROM;
            cfg_reg.wram_mode         <= RESET_WRAM_MODE;
            cfg_reg.initial_mirroring <= RESET_INIT_MIRROR;
            bit_count_reg  <= 3'd0;
            shift_reg      <= 5'd0;
            ctrl_reg       <= CTRL_RESET;
            chr_a_reg      <= 5'd0;
            chr_b_reg      <= 5'd0;
            prg_reg        <= 5'd0;
            last_sel_reg   <= SEL_CONTROL;
            wram_count_reg <= 3'd0;
            wram_sum_reg   <= 3'd0;
            mirroring_reg  <= RESET_INIT_MIRROR;
            prg_low_reg    <= 6'd0;
            prg_high_reg   <= 6'(RESET_ROM_BANKS - 7'd1);
            chr_low_reg    <= 5'd0;
            chr_high_reg   <= CHR_RESET_HI;
            wram_page_reg  <= 1'b0;
            loaded_reg     <= 1'b0;
        end
        else if (cfg_hit)
        begin
            // cartridge swap: state restarts from the new configuration
            cfg_reg        <= cfg_next;
            bit_count_reg  <= 3'd0;
            shift_reg      <= 5'd0;
            ctrl_reg       <= CTRL_RESET;
            chr_a_reg      <= 5'd0;
            chr_b_reg      <= 5'd0;
            prg_reg        <= 5'd0;
            last_sel_reg   <= SEL_CONTROL;
            wram_count_reg <= 3'd0;
            wram_sum_reg   <= 3'd0;
            mirroring_reg  <= cfg_next.initial_mirroring;
            prg_low_reg    <= 6'd0;
            prg_high_reg   <= reset_prg_high;
            chr_low_reg    <= 5'd0;
            chr_high_reg   <= CHR_RESET_HI;
            wram_page_reg  <= 1'b0;
            loaded_reg     <= 1'b0;
        end
        else if (s1_fire)
        begin
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            ctrl_reg       <= ctrl_next;
            chr_a_reg      <= chr_a_next;
            chr_b_reg      <= chr_b_next;
            prg_reg        <= prg_next;
            last_sel_reg   <= last_sel_next;
            wram_count_reg <= wram_count_next;
            wram_sum_reg   <= wram_sum_next;
            mirroring_reg  <= mirroring_next;
            prg_low_reg    <= prg_low_next;
            prg_high_reg   <= prg_high_next;
            chr_low_reg    <= chr_low_next;
            chr_high_reg   <= chr_high_next;
            wram_page_reg  <= wram_page_next;
            loaded_reg     <= loaded_next;
        end
    end

    // the bank state moves when a new result enters the output register, on a configuration write and on reset
    assign mirroring       = mirroring_reg;
    assign prg_bank_low    = prg_low_reg;
    assign prg_bank_high   = prg_high_reg;
    assign chr_bank_low    = chr_low_reg;
    assign chr_bank_high   = chr_high_reg;
    assign wram_page       = wram_page_reg;
    assign register_loaded = loaded_reg;

endmodule

/* hdl/sbm_checker.sv */
module sbm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [1:0]                     mirroring,
    input logic [5:0]                     prg_bank_low,
    input logic [5:0]                     prg_bank_high,
    input logic [4:0]                     chr_bank_low,
    input logic [4:0]                     chr_bank_high,
    input logic                           wram_page,
    input logic                           register_loaded
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mirroring)
            && $stable(prg_bank_low) && $stable(prg_bank_high)
            && $stable(chr_bank_low) && $stable(chr_bank_high)
            && $stable(wram_page) && $stable(register_loaded))
        else $error("result changed while stalled");

    // input only backs up when the output side is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output register");

    // an accepted transaction passes the input register and reaches the output register when not blocked
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall |=> out_valid)
        else $error("result transaction missing");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid && !in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind serial_bank_mapper_unit sbm_checker u_sbm_checker (.*);

/* verif/serial_bank_mapper_unit_test.sv */
`timescale 1ns / 1ps

module serial_bank_mapper_unit_test;
    import sbm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 36;
    localparam int HOLD_CYCLES = 300;

    localparam logic [1:0] WRAM_MODE_NONE    = 2'd0;
    localparam logic [1:0] WRAM_MODE_ALT     = 2'd3;
    localparam logic [1:0] MIRROR_SINGLE_LO  = 2'd0;
    localparam logic [1:0] MIRROR_SINGLE_HI  = 2'd1;
    localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
    localparam logic [1:0] MIRROR_HORIZONTAL = 2'd3;
    localparam logic [7:0] DATA_RESET        = 8'h80;

    typedef struct packed {
        logic [1:0] mirroring;
        logic [5:0] prg_low;
        logic [5:0] prg_high;
        logic [4:0] chr_low;
        logic [4:0] chr_high;
        logic       wram_page;
        logic       loaded;
    } bank_map_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [15:0]            addr;
    logic [7:0]             data;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             mirroring;
    logic [5:0]             prg_bank_low;
    logic [5:0]             prg_bank_high;
    logic [4:0]             chr_bank_low;
    logic [4:0]             chr_bank_high;
    logic                   wram_page;
    logic                   register_loaded;

    // cartridge setup and mapper state as the testbench tracks them
    cfg_t       cart;
    logic [2:0] bit_cnt;
    logic [4:0] shift_reg;
    logic [4:0] ctrl_reg;
    logic [4:0] chr_a_reg;
    logic [4:0] chr_b_reg;
    logic [4:0] prg_reg;
    logic [1:0] prev_sel;
    logic [2:0] bfff_count;
    logic [2:0] bfff_sum;
    bank_map_t  banks;

    bank_map_t  pending_maps[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         src_idle_pct = IDLE_PCT;
    int         sink_idle_pct = IDLE_PCT;
    logic       hold_request = 1'b0;
    int         hold_left = 0;

    serial_bank_mapper_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .addr            (addr),
        .data            (data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mirroring       (mirroring),
        .prg_bank_low    (prg_bank_low),
        .prg_bank_high   (prg_bank_high),
        .chr_bank_low    (chr_bank_low),
        .chr_bank_high   (chr_bank_high),
        .wram_page       (wram_page),
        .register_loaded (register_loaded)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic is_large();
        return cart.rom_banks_16k >= LARGE_BANKS;
    endfunction

    function automatic logic [5:0] last_bank();
        return 6'(cart.rom_banks_16k - 7'd1);
    endfunction

    // cartridge insertion: mapper state back to its reset values for the current cartridge
    function automatic void restore_state();
        bit_cnt    = '0;
        shift_reg  = '0;
        ctrl_reg   = CTRL_RESET;
        chr_a_reg  = '0;
        chr_b_reg  = '0;
        prg_reg    = '0;
        prev_sel   = SEL_CONTROL;
        bfff_count = '0;
        bfff_sum   = '0;
        banks.mirroring = cart.initial_mirroring;
        banks.prg_low   = '0;
        banks.prg_high  = is_large() ? LARGE_FIXED : last_bank();
        banks.chr_low   = '0;
        banks.chr_high  = CHR_RESET_HI;
        banks.wram_page = 1'b0;
        banks.loaded    = 1'b0;
    endfunction

    function automatic void update_chr_rom();
        if (ctrl_reg[4])
        begin
            banks.chr_low  = chr_a_reg;
            banks.chr_high = chr_b_reg;
        end
        else
        begin
            banks.chr_low  = chr_a_reg & 5'h1e;
            banks.chr_high = banks.chr_low | 5'd1;
        end
    endfunction

    function automatic void load_normal(input logic [1:0] sel);
        case (sel) inside
            SEL_CONTROL: banks.mirroring = ctrl_reg[1:0];
            SEL_CHR_A, SEL_CHR_B:
            begin
                if (cart.has_chr_rom)
                    update_chr_rom();
                else if (ctrl_reg[4])
                begin
                    // chr ram: each register only moves its own half
                    if (sel == SEL_CHR_A)
                        banks.chr_low = chr_a_reg;
                    else
                        banks.chr_high = chr_b_reg;
                end
            end
            default:
            begin
                if (!ctrl_reg[3])
                begin
                    banks.prg_low  = {1'b0, prg_reg & 5'h1e};
                    banks.prg_high = banks.prg_low + 6'd1;
                end
                else if (ctrl_reg[2])
                begin
                    banks.prg_low  = {1'b0, prg_reg};
                    banks.prg_high = last_bank();
                end
                else
                begin
                    banks.prg_low  = '0;
                    banks.prg_high = {1'b0, prg_reg};
                end
            end
        endcase
    endfunction

    // large carts recompute the prg banks and, where allowed, the chr banks on every load, with a 256k base
    function automatic void load_large(input logic [1:0] sel);
        logic [5:0] base;
        base = chr_a_reg[4] ? 6'd16 : 6'd0;
        if (cart.wram_mode == WRAM_MODE_CHR)
            banks.wram_page = |chr_a_reg[4:3];
        if (sel == SEL_CONTROL)
            banks.mirroring = ctrl_reg[1:0];
        if (cart.has_chr_rom)
            update_chr_rom();
        else if (ctrl_reg[4])
        begin
            banks.chr_low  = chr_a_reg;
            banks.chr_high = chr_b_reg;
        end
        if (!ctrl_reg[3])
        begin
            banks.prg_low  = base + {2'b00, prg_reg[3:1], 1'b0};
            banks.prg_high = banks.prg_low + 6'd1;
        end
        else if (ctrl_reg[2])
        begin
            banks.prg_low  = base + {2'b00, prg_reg[3:0]};
            banks.prg_high = base + LARGE_FIXED;
        end
        else
        begin
            banks.prg_high = base + {2'b00, prg_reg[3:0]};
            banks.prg_low  = base;
        end
    endfunction

    function automatic bank_map_t next_bank_map(input logic [15:0] a, input logic [7:0] d);
        logic [1:0] sel;
        sel = a[14:13];
        banks.loaded = 1'b0;
        // five writes to bfff pick the work ram page, reset writes included
        if (cart.wram_mode == WRAM_MODE_BFFF && a == BFFF_ADDR)
        begin
            bfff_count = bfff_count + 3'd1;
            bfff_sum   = bfff_sum + {2'b00, d[0]};
            if (bfff_count == WRAM_WRITES)
            begin
                banks.wram_page = (bfff_sum != 3'd0);
                bfff_count = '0;
                bfff_sum   = '0;
            end
        end
        if (!is_large())
        begin
            if (sel != prev_sel)
            begin
                bit_cnt   = '0;
                shift_reg = '0;
            end
            prev_sel = sel;
        end
        if (d[7])
        begin
            bit_cnt   = '0;
            shift_reg = '0;
            ctrl_reg  = ctrl_reg | CTRL_PRG_MODE;
        end
        else
        begin
            if (d[0])
                shift_reg = shift_reg | (5'd1 << bit_cnt);
            bit_cnt = bit_cnt + 3'd1;
            if (bit_cnt >= LOAD_BITS)
            begin
                case (sel)
                    SEL_CONTROL: ctrl_reg  = shift_reg;
                    SEL_CHR_A:   chr_a_reg = shift_reg;
                    SEL_CHR_B:   chr_b_reg = shift_reg;
                    default:     prg_reg   = shift_reg;
                endcase
                shift_reg    = '0;
                bit_cnt      = '0;
                banks.loaded = 1'b1;
                if (is_large())
                    load_large(sel);
                else
                    load_normal(sel);
            end
        end
        return banks;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [5:0] got,
                               input logic [5:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // one cpu write transaction, with a random gap in front of it
    task automatic send_write(input logic [15:0] a, input logic [7:0] d);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        addr     <= a;
        data     <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_maps.push_back(next_bank_map(a, d));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        wait_for_results();
        repeat (4) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_ROM_BANKS:   cart.rom_banks_16k     = val[6:0];
            CFG_HAS_CHR_ROM: cart.has_chr_rom       = val[0];
            CFG_WRAM_MODE:   cart.wram_mode         = val[1:0];
            CFG_INIT_MIRROR: cart.initial_mirroring = val[1:0];
            default: ;
        endcase
        restore_state();
    endtask

    task automatic load_register(input logic [1:0] sel, input logic [4:0] val);
        for (int i = 0; i < 5; i++)
            send_write({1'b1, sel, 13'(i * 397)}, {7'd0, val[i]});
    endtask

    function automatic logic [15:0] random_addr(input logic [1:0] sel);
        logic [15:0] a;
        a = 16'($urandom);
        a[14:13] = sel;
        a[15] = ($urandom_range(9) != 0);
        if (sel == SEL_CHR_A && $urandom_range(4) == 0)
            a = BFFF_ADDR;
        return a;
    endfunction

    // mostly complete five-bit loads, some cut short, some plain noise
    task automatic run_random(input int count);
        int         sent;
        int         kind;
        int         n_bits;
        logic [1:0] sel;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(99);
            sel  = 2'($urandom_range(3));
            if (kind < 70)
            begin
                if ($urandom_range(3) == 0)
                begin
                    send_write(random_addr(sel), DATA_RESET | 8'($urandom));
                    sent++;
                end
                for (int i = 0; i < 5; i++)
                    send_write(random_addr(sel), {1'b0, 7'($urandom)});
                sent += 5;
            end
            else if (kind < 85)
            begin
                n_bits = $urandom_range(1, 4);
                for (int i = 0; i < n_bits; i++)
                    send_write(random_addr(sel), {1'b0, 7'($urandom)});
                sent += n_bits;
            end
            else
            begin
                send_write(16'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    task automatic set_cartridge(input logic [6:0] rom_banks, input logic chr_rom,
                                 input logic [1:0] wmode, input logic [1:0] mirror);
        write_setting(CFG_ROM_BANKS, rom_banks);
        write_setting(CFG_HAS_CHR_ROM, CFG_DATA_W'(chr_rom));
        write_setting(CFG_WRAM_MODE, CFG_DATA_W'(wmode));
        write_setting(CFG_INIT_MIRROR, CFG_DATA_W'(mirror));
    endtask

    task automatic test_directed_writes();
        send_write(16'h8000, DATA_RESET);
        // 32k prg, 4k-pair chr, horizontal mirroring
        load_register(SEL_CONTROL, 5'b10011);
        load_register(SEL_CHR_A, 5'h1f);
        load_register(SEL_PRG, 5'h1f);
        // two bits into chr a, then the select moves to prg
        send_write(16'ha000, 8'h01);
        send_write(16'ha001, 8'h01);
        send_write(16'he000, 8'h7e);
        // selects still decode below 8000
        send_write(16'h0000, 8'h00);
        send_write(16'h7fff, 8'hff);
        send_write(16'hffff, 8'h7f);
        send_write(BFFF_ADDR, 8'h00);
    endtask

    task automatic test_cartridge_types();
        set_cartridge(7'd2,  1'b0, WRAM_MODE_NONE, MIRROR_SINGLE_LO);
        run_random(190);
        set_cartridge(7'd64, 1'b1, WRAM_MODE_CHR,  MIRROR_HORIZONTAL);
        run_random(190);
        set_cartridge(7'd31, 1'b0, WRAM_MODE_BFFF, MIRROR_SINGLE_HI);
        run_random(190);
        set_cartridge(7'd32, 1'b0, WRAM_MODE_CHR,  MIRROR_VERTICAL);
        run_random(190);
        set_cartridge(7'd16, 1'b1, WRAM_MODE_BFFF, MIRROR_HORIZONTAL);
        run_random(190);
        set_cartridge(7'd48, 1'b1, WRAM_MODE_ALT,  MIRROR_SINGLE_LO);
        run_random(190);
        set_cartridge(7'd64, 1'b0, WRAM_MODE_BFFF, MIRROR_VERTICAL);
        run_random(190);
        // page from chr bits only applies to large carts
        set_cartridge(7'd5,  1'b1, WRAM_MODE_CHR,  MIRROR_SINGLE_HI);
        run_random(190);
    endtask

    // output held off for a long stretch while writes keep coming
    task automatic test_output_hold();
        hold_request = 1'b1;
        run_random(120);
        wait_for_results();
    endtask

    task automatic test_full_rate();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(300);
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
    endtask

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        bank_map_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_maps.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
            begin
                want = pending_maps.pop_front();
                check_field("mirroring", 6'(mirroring), 6'(want.mirroring));
                check_field("prg_bank_low", prg_bank_low, want.prg_low);
                check_field("prg_bank_high", prg_bank_high, want.prg_high);
                check_field("chr_bank_low", 6'(chr_bank_low), 6'(want.chr_low));
                check_field("chr_bank_high", 6'(chr_bank_high), 6'(want.chr_high));
                check_field("wram_page", 6'(wram_page), 6'(want.wram_page));
                check_field("register_loaded", 6'(register_loaded), 6'(want.loaded));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("serial_bank_mapper_unit test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        addr         <= '0;
        data         <= '0;
        out_stall    <= 1'b0;
        cart.rom_banks_16k     = RESET_ROM_BANKS;
        cart.has_chr_rom       = RESET_HAS_CHR_ROM;
        cart.wram_mode         = RESET_WRAM_MODE;
        cart.initial_mirroring = RESET_INIT_MIRROR;
        restore_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_writes();
        test_cartridge_types();
        test_output_hold();
        test_full_rate();

        wait_for_results();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("serial_bank_mapper_unit test passed");
        else
            $display("serial_bank_mapper_unit test failed");
        $finish;
    end

endmodule
